>>> rtl/core/rtc_three_wire_serial_master_macros.svh
// ----------------------------------------------------------------------------
// rtc_three_wire_serial_master_macros
// Assertion macros for the three-wire RTC serial master.
// ----------------------------------------------------------------------------
`ifndef RTC_THREE_WIRE_SERIAL_MASTER_MACROS_SVH
`define RTC_THREE_WIRE_SERIAL_MASTER_MACROS_SVH

// Implication checked on the same edge
`define RTC3W_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Implication checked on the following edge
`define RTC3W_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/rtc3w_pkg.sv
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Types and constants for the three-wire RTC serial master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

    typedef struct packed {
        logic       start_req;
        logic       op;
        logic [5:0] address;
        logic [7:0] write_data;
        logic       io_in;
    } rtc3w_tick_t;

    typedef struct packed {
        logic       ce_pin;
        logic       sclk_pin;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } rtc3w_res_t;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_SETUP    = 3'd1;
    localparam logic [2:0] PH_CMD_LOW  = 3'd2;
    localparam logic [2:0] PH_CMD_HIGH = 3'd3;
    localparam logic [2:0] PH_RD_LOW   = 3'd4;
    localparam logic [2:0] PH_RD_HIGH  = 3'd5;

    localparam logic [7:0] CMD_MARK        = 8'h80;
    localparam logic [3:0] RD_LAST_BIT     = 4'd7;
    localparam logic [3:0] WR_LAST_BIT     = 4'd15;
    localparam logic [7:0] HALF_PERIOD_RST = 8'd8;
    localparam logic       REG_HALF_PERIOD = 1'b0;

endpackage

>>> rtl/core/rtc_three_wire_serial_master.sv
// ----------------------------------------------------------------------------
// rtc_three_wire_serial_master
// Pin sequencer for a three-wire RTC bus: CE, SCLK and a bidirectional IO.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+----------------------
//   tick     | in  | tick_valid / tick_stall | rtc3w_tick_t (1 tick)
//   res      | out | res_valid / res_stall   | rtc3w_res_t (pin state)
//   config   | in  | APB psel/penable/pready | half_period at 0x0
//
// One tick is accepted per cycle while tick_stall is low; its pin state is
// registered. The sequencer state update is one pass of logic.
// A skid register holds a second result while res is stalled; tick_stall
// rises only when both output slots are full.
// Reset clears the sequencer, the output slots and sets half_period to 8.
// ----------------------------------------------------------------------------
`include "rtc_three_wire_serial_master_macros.svh"

module rtc_three_wire_serial_master (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  rtc3w_pkg::rtc3w_tick_t tick,
    output logic                  res_valid,
    input  logic                  res_stall,
    output rtc3w_pkg::rtc3w_res_t res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import rtc3w_pkg::*;

    logic [7:0]  half_period_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  tick_count_reg, tick_count_next;
    logic [15:0] shift_out_reg, shift_out_next;
    logic [7:0]  shift_in_reg, shift_in_next;
    logic        is_read_reg, is_read_next;
    logic [7:0]  last_read_reg, last_read_next;

    logic        out_valid_reg, skid_valid_reg;
    rtc3w_res_t  out_data_reg, skid_data_reg;
    rtc3w_res_t  res_new;
    logic        accept_in, take_out, done;
    logic [8:0]  tick_inc;
    logic [7:0]  hp;
    logic [3:0]  last_bit;
    logic [7:0]  sample;

    assign pready     = 1'b1;
    assign tick_stall = skid_valid_reg;
    assign accept_in  = tick_valid && !skid_valid_reg;
    assign take_out   = out_valid_reg && !res_stall;
    assign res_valid  = out_valid_reg;
    assign res        = out_data_reg;
    assign prdata     = (paddr[2] == REG_HALF_PERIOD) ? {24'd0, half_period_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RST;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_HALF_PERIOD)
        begin
            half_period_reg <= pwdata[7:0];
        end
    end

    // next sequencer state for the tick being accepted
    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        tick_count_next = tick_count_reg;
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        is_read_next    = is_read_reg;
        last_read_next  = last_read_reg;
        done            = 1'b0;
        tick_inc        = {1'b0, tick_count_reg} + 9'd1;
        hp              = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
        last_bit        = is_read_reg ? RD_LAST_BIT : WR_LAST_BIT;
        sample          = {tick.io_in, shift_in_reg[7:1]};

        if (phase_reg == PH_IDLE || phase_reg > PH_RD_HIGH)
        begin
            phase_next = PH_IDLE;
            if (tick.start_req)
            begin
                is_read_next    = tick.op;
                shift_out_next  = {tick.write_data, CMD_MARK | {1'b0, tick.address, tick.op}};
                shift_in_next   = 8'd0;
                bit_count_next  = 4'd0;
                tick_count_next = 8'd0;
                phase_next      = PH_SETUP;
            end
        end
        else if (tick_inc >= {1'b0, hp})
        begin
            tick_count_next = 8'd0;
            case (phase_reg)
                PH_SETUP:    phase_next = PH_CMD_LOW;
                PH_CMD_LOW:  phase_next = PH_CMD_HIGH;
                PH_CMD_HIGH:
                begin
                    shift_out_next = shift_out_reg >> 1;
                    if (bit_count_reg >= last_bit)
                    begin
                        bit_count_next = 4'd0;
                        if (is_read_reg)
                        begin
                            phase_next = PH_RD_LOW;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + 4'd1;
                        phase_next     = PH_CMD_LOW;
                    end
                end
                PH_RD_LOW:
                begin
                    shift_in_next = sample;
                    if (bit_count_reg >= RD_LAST_BIT)
                    begin
                        bit_count_next = 4'd0;
                        last_read_next = sample;
                        phase_next     = PH_IDLE;
                        done           = 1'b1;
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + 4'd1;
                        phase_next     = PH_RD_HIGH;
                    end
                end
                PH_RD_HIGH:  phase_next = PH_RD_LOW;
                default:     phase_next = PH_IDLE;
            endcase
        end
        else
        begin
            tick_count_next = tick_inc[7:0];
        end
    end

    // pin levels after this tick
    always_comb
    begin
        res_new           = '0;
        res_new.busy_res  = (phase_next != PH_IDLE);
        res_new.done_res  = done;
        res_new.read_data = last_read_next;
        case (phase_next)
            PH_CMD_LOW:
            begin
                res_new.ce_pin   = 1'b1;
                res_new.io_drive = 1'b1;
                res_new.io_out   = shift_out_next[0];
            end
            PH_CMD_HIGH:
            begin
                res_new.ce_pin   = 1'b1;
                res_new.sclk_pin = 1'b1;
                res_new.io_drive = 1'b1;
                res_new.io_out   = shift_out_next[0];
            end
            PH_RD_LOW:
            begin
                res_new.ce_pin = 1'b1;
            end
            PH_RD_HIGH:
            begin
                res_new.ce_pin   = 1'b1;
                res_new.sclk_pin = 1'b1;
            end
            default:
            begin
                res_new.ce_pin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 4'd0;
            tick_count_reg <= 8'd0;
            shift_out_reg  <= 16'd0;
            shift_in_reg   <= 8'd0;
            is_read_reg    <= 1'b0;
            last_read_reg  <= 8'd0;
        end
        else if (accept_in)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            tick_count_reg <= tick_count_next;
            shift_out_reg  <= shift_out_next;
            shift_in_reg   <= shift_in_next;
            is_read_reg    <= is_read_next;
            last_read_reg  <= last_read_next;
        end
    end

    // output slot plus skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take_out)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept_in)
        begin
            if (!out_valid_reg || take_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take_out)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take_out)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept_in)
        begin
            if (!out_valid_reg || take_out)
            begin
                out_data_reg <= res_new;
            end
            else
            begin
                skid_data_reg <= res_new;
            end
        end
    end

    `RTC3W_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `RTC3W_ASSERT_IMP(a_done_not_busy, clk, rst_n, res_valid && res.done_res, !res.busy_res && !res.ce_pin, "done while still busy")
    `RTC3W_ASSERT_IMP(a_idle_tick_clear, clk, rst_n, phase_reg == PH_IDLE, tick_count_reg == 8'd0, "idle with running tick count")
    `RTC3W_ASSERT_NEXT(a_stall_holds_state, clk, rst_n, tick_stall, $stable(phase_reg) && $stable(tick_count_reg), "state moved during stall")

endmodule
